// ----- rtl/core/rsba_pkg.sv -----
// Shared types, constants and sample conditioning functions for the sensor block averager.
`timescale 1ns / 1ps

package rsba_pkg;

   localparam int NUM_CH   = 5;
   localparam int CH_REF   = 0;
   localparam int CH_TEMP  = 1;
   localparam int CH_MOTOR = 2;
   localparam int CH_LIGHT = 3;
   localparam int CH_AUX   = 4;

   localparam int RAW_W    = 8;
   localparam int TEMP_W   = 9;
   localparam int MOTOR_W  = 7;

   // Temperature bytes below this value have wrapped past 255.
   localparam logic [RAW_W-1:0] UNWRAP_LIMIT = 8'd50;

   // floor(2*x / 5) for 2*x < 512 as (2*x * 820) >> 12, exact over that range.
   localparam int MOTOR_MUL_W = 19;
   localparam logic [9:0] MOTOR_RECIP = 10'd820;
   localparam int MOTOR_SHIFT = 12;

   localparam int AVG_RST_REF   = 200;
   localparam int AVG_RST_TEMP  = 200;
   localparam int AVG_RST_MOTOR = 51;
   localparam int AVG_RST_LIGHT = 0;
   localparam int AVG_RST_AUX   = 200;

   typedef struct packed {
      logic acc_en;   // a beat enters the accumulate stage
      logic fwd_en;   // accumulate stage moves into the result register
   } rsba_ctl_type;

   function automatic logic [TEMP_W-1:0] rsba_unwrap(input logic [RAW_W-1:0] raw);
      logic [TEMP_W-1:0] res;
      res = {(raw < UNWRAP_LIMIT), raw};
      return res;
   endfunction

   function automatic logic [MOTOR_W-1:0] rsba_motor_scale(input logic [RAW_W-1:0] raw);
      logic [MOTOR_MUL_W-1:0] prod;
      prod = MOTOR_MUL_W'({raw, 1'b0}) * MOTOR_MUL_W'(MOTOR_RECIP);
      return prod[MOTOR_SHIFT +: MOTOR_W];
   endfunction

endpackage

// ----- rtl/core/rsba_lane.sv -----
// One channel lane: sample accumulation, block end detection and reciprocal divide.
`timescale 1ns / 1ps

module rsba_lane
   import rsba_pkg::*;
#(
   parameter int VAL_W     = 8,
   parameter int BLOCK_LEN = 20,
   parameter int AVG_RESET = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  rsba_ctl_type     ctl,
   input  logic             sample_valid,
   input  logic [VAL_W-1:0] sample,
   output logic [VAL_W-1:0] average,
   output logic             fresh
);

   localparam int CNT_W   = $clog2(BLOCK_LEN + 1);
   localparam int SUM_W   = VAL_W + CNT_W;
   localparam int DIV_L   = $clog2(BLOCK_LEN);
   localparam int SHIFT   = SUM_W + DIV_L;
   localparam int RECIP_W = SUM_W + 1;
   localparam int RECIP   = (2**SHIFT + BLOCK_LEN - 1) / BLOCK_LEN;
   localparam int PROD_W  = SUM_W + RECIP_W;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  total_ff, total_in;
   logic              done_ff, done_in;
   logic [VAL_W-1:0]  avg_ff, avg_in;
   logic              fresh_ff, fresh_in;

   logic [SUM_W-1:0]  sum_acc;
   logic [CNT_W-1:0]  cnt_acc;
   logic              block_end;
   logic [PROD_W-1:0] prod;

   assign sum_acc   = sum_ff + SUM_W'(sample);
   assign cnt_acc   = cnt_ff + CNT_W'(1);
   assign block_end = (cnt_acc == CNT_W'(BLOCK_LEN));

   // Exact floor(total / BLOCK_LEN) for any total below 2**SUM_W.
   assign prod = PROD_W'(total_ff) * PROD_W'(RECIP);

   always_comb begin
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      done_in  = done_ff;
      avg_in   = avg_ff;
      fresh_in = fresh_ff;
      if (ctl.acc_en) begin
         total_in = sum_acc;
         done_in  = sample_valid && block_end;
         if (sample_valid) begin
            if (block_end) begin
               sum_in = '0;
               cnt_in = '0;
            end else begin
               sum_in = sum_acc;
               cnt_in = cnt_acc;
            end
         end
      end
      if (ctl.fwd_en) begin
         fresh_in = done_ff;
         if (done_ff) begin
            avg_in = prod[SHIFT +: VAL_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
         avg_ff   <= VAL_W'(AVG_RESET);
         fresh_ff <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
         avg_ff   <= avg_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   assign average = avg_ff;
   assign fresh   = fresh_ff;

endmodule

// ----- rtl/core/radiator_sensor_block_averager_core.sv -----
// Top level of the sensor block averager: five channel lanes and the result merge.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | five samples, each with a valid flag
//   rsp     | out       | rsp_valid/rsp_stall  | five averages, three conditioned values,
//           |           |                      | online flag, fresh mask
//
// One beat per cycle is sustained while rsp_stall is low; a taken beat waits in the
// accumulate stage and moves into the result register on the rsp ports when it advances.
// Each lane's reciprocal multiply sits between the accumulate stage and the result register.
// Reset is synchronous: sums and counts clear, averages load their start values.
// rsp_stall holds the result register; the accumulate stage still takes one more beat,
// after which req_stall rises until the result is taken.
`timescale 1ns / 1ps

module radiator_sensor_block_averager_core
   import rsba_pkg::*;
#(
   parameter int BLOCK_LEN = 20
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [RAW_W-1:0]   req_ref_sample,
   input  logic               req_ref_valid,
   input  logic [RAW_W-1:0]   req_temp_sample,
   input  logic               req_temp_valid,
   input  logic [RAW_W-1:0]   req_motor_sample,
   input  logic               req_motor_valid,
   input  logic [RAW_W-1:0]   req_light_sample,
   input  logic               req_light_valid,
   input  logic [RAW_W-1:0]   req_aux_sample,
   input  logic               req_aux_valid,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [RAW_W-1:0]   rsp_ref_average,
   output logic [TEMP_W-1:0]  rsp_temp_average,
   output logic [MOTOR_W-1:0] rsp_motor_average,
   output logic [RAW_W-1:0]   rsp_light_average,
   output logic [TEMP_W-1:0]  rsp_aux_average,
   output logic [TEMP_W-1:0]  rsp_temp_now,
   output logic [MOTOR_W-1:0] rsp_motor_now,
   output logic [TEMP_W-1:0]  rsp_aux_now,
   output logic               rsp_unit_online,
   output logic [NUM_CH-1:0]  rsp_fresh_mask
);

   rsba_ctl_type       ctl;
   logic               accept;
   logic               advance;

   logic [TEMP_W-1:0]  temp_now, aux_now;
   logic [MOTOR_W-1:0] motor_now;

   logic               a_valid_ff, a_valid_in;
   logic [TEMP_W-1:0]  a_temp_ff, a_aux_ff;
   logic [MOTOR_W-1:0] a_motor_ff;
   logic               a_online_ff;

   logic               out_valid_ff, out_valid_in;
   logic [TEMP_W-1:0]  out_temp_ff, out_aux_ff;
   logic [MOTOR_W-1:0] out_motor_ff;
   logic               out_online_ff;

   assign advance   = a_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = a_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign ctl.acc_en = accept;
   assign ctl.fwd_en = advance;

   assign temp_now  = req_temp_valid  ? rsba_unwrap(req_temp_sample)       : '0;
   assign aux_now   = req_aux_valid   ? rsba_unwrap(req_aux_sample)        : '0;
   assign motor_now = req_motor_valid ? rsba_motor_scale(req_motor_sample) : '0;

   rsba_lane #(.VAL_W(RAW_W), .BLOCK_LEN(BLOCK_LEN), .AVG_RESET(AVG_RST_REF)) u_ref (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sample_valid (req_ref_valid),
      .sample       (req_ref_sample),
      .average      (rsp_ref_average),
      .fresh        (rsp_fresh_mask[CH_REF])
   );

   rsba_lane #(.VAL_W(TEMP_W), .BLOCK_LEN(BLOCK_LEN), .AVG_RESET(AVG_RST_TEMP)) u_temp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sample_valid (req_temp_valid),
      .sample       (temp_now),
      .average      (rsp_temp_average),
      .fresh        (rsp_fresh_mask[CH_TEMP])
   );

   rsba_lane #(.VAL_W(MOTOR_W), .BLOCK_LEN(BLOCK_LEN), .AVG_RESET(AVG_RST_MOTOR)) u_motor (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sample_valid (req_motor_valid),
      .sample       (motor_now),
      .average      (rsp_motor_average),
      .fresh        (rsp_fresh_mask[CH_MOTOR])
   );

   rsba_lane #(.VAL_W(RAW_W), .BLOCK_LEN(BLOCK_LEN), .AVG_RESET(AVG_RST_LIGHT)) u_light (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sample_valid (req_light_valid),
      .sample       (req_light_sample),
      .average      (rsp_light_average),
      .fresh        (rsp_fresh_mask[CH_LIGHT])
   );

   rsba_lane #(.VAL_W(TEMP_W), .BLOCK_LEN(BLOCK_LEN), .AVG_RESET(AVG_RST_AUX)) u_aux (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sample_valid (req_aux_valid),
      .sample       (aux_now),
      .average      (rsp_aux_average),
      .fresh        (rsp_fresh_mask[CH_AUX])
   );

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Carry the per-poll values alongside the lane pipeline.
   always_ff @(posedge clock) begin
      if (accept) begin
         a_temp_ff   <= temp_now;
         a_motor_ff  <= motor_now;
         a_aux_ff    <= aux_now;
         a_online_ff <= req_motor_valid;
      end
      if (advance) begin
         out_temp_ff   <= a_temp_ff;
         out_motor_ff  <= a_motor_ff;
         out_aux_ff    <= a_aux_ff;
         out_online_ff <= a_online_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_temp_now    = out_temp_ff;
   assign rsp_motor_now   = out_motor_ff;
   assign rsp_aux_now     = out_aux_ff;
   assign rsp_unit_online = out_online_ff;

`ifndef SYNTHESIS
   a_stall_needs_held_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff)
      else $error("req_stall raised with an empty accumulate stage");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("beat lost between accumulate stage and result register");

   a_motor_implies_online: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_motor_now != '0) |-> rsp_unit_online)
      else $error("nonzero motor value reported while unit offline");

   a_temp_unwrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temp_now == '0 || rsp_temp_now >= TEMP_W'(UNWRAP_LIMIT)))
      else $error("temperature value below unwrap limit");
`endif

endmodule
